@@ sv/mzs_pkg.sv @@
// ----------------------------------------------------------------------------
// mzs_pkg: shared types and constants for the morton particle sorter
// capacity, field widths and register indexes
// ----------------------------------------------------------------------------
package mzs_pkg;
   localparam int MAX_PARTICLES = 64;
   localparam int IDX_W = $clog2(MAX_PARTICLES);
   localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
   localparam int ADDR_W = 5;
   localparam logic [31:0] CELL_MAX = 32'hFFFF_FFFF;

   localparam logic [ADDR_W-1:0] REG_LEFT = 5'd0;
   localparam logic [ADDR_W-1:0] REG_BOTTOM = 5'd8;
   localparam logic [ADDR_W-1:0] REG_SCALE_X = 5'd16;
   localparam logic [ADDR_W-1:0] REG_SCALE_Y = 5'd24;

   typedef struct packed {
      logic signed [31:0] position_x;
      logic signed [31:0] position_y;
      logic [31:0] mass_word;
      logic [31:0] velocity_x;
      logic [31:0] velocity_y;
      logic last_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sorted_x;
      logic signed [31:0] sorted_y;
      logic [31:0] sorted_mass;
      logic [31:0] sorted_vel_x;
      logic [31:0] sorted_vel_y;
      logic [63:0] morton_code;
      logic [5:0] source_index;
      logic overflowed;
      logic last_out;
   } rsp_type;
endpackage

@@ sv/mzs_if.sv @@
// ----------------------------------------------------------------------------
// mzs_req_if / mzs_rsp_if: valid-ready channels
// carry one particle or one sorted result per transfer
// ----------------------------------------------------------------------------
interface mzs_req_if import mzs_pkg::*; ;
   logic valid;
   logic ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface mzs_rsp_if import mzs_pkg::*; ;
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ sv/morton_zorder_particle_sort.sv @@
// ----------------------------------------------------------------------------
// morton_zorder_particle_sort: z-order sorter for a set of 2-D particles
// loads particles, sorts by interleaved grid code, streams them back
// ----------------------------------------------------------------------------
// req carries one particle per transfer; last_in closes the set. each
// particle is loaded with one shared 33x24 multiplier, which produces
// the x and y cells over four steps, then the code is written. after the
// last particle a stable insertion sort runs on one shared 64-bit
// comparator; each compare step reads the previous order entry, then its
// code, then compares and moves. results then stream out through a
// registered memory read and an output register, one at a time. req is
// low while a particle loads and, after last_in, until the last result
// transfer of the run.
// a stalled rsp holds the result and the sequencer waits; nothing is lost.
// particles beyond 64 are dropped and flag overflowed on every result.
// reset (synchronous) empties the set and restores the register defaults;
// the stores themselves are not cleared. csr is APB-style, 64-bit data,
// registers at byte offsets 0, 8, 16, 24, pready always high.
// ----------------------------------------------------------------------------
module morton_zorder_particle_sort import mzs_pkg::*; (
   input  logic clock,
   input  logic reset,
   mzs_req_if.sink req,
   mzs_rsp_if.source rsp,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic csr_pready
);
   typedef enum logic [10:0] {
      ST_IDLE = 11'b00000000001,
      ST_MUL = 11'b00000000010,
      ST_WRITE = 11'b00000000100,
      ST_SORT_I = 11'b00000001000,
      ST_SORT_K = 11'b00000010000,
      ST_SORT_J = 11'b00000100000,
      ST_SORT_C = 11'b00001000000,
      ST_SORT_M = 11'b00010000000,
      ST_SORT_P = 11'b00100000000,
      ST_OUT_RD = 11'b01000000000,
      ST_OUT_LD = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic signed [31:0] left_ff, bottom_ff;
   logic [47:0] scale_x_ff, scale_y_ff;
   logic [CNT_W-1:0] count_ff;
   logic ovf_ff;

   // memories
   logic [63:0] pos_mem [MAX_PARTICLES];
   logic [63:0] vel_mem [MAX_PARTICLES];
   logic [31:0] mass_mem [MAX_PARTICLES];
   logic [63:0] code_mem [MAX_PARTICLES];
   logic [IDX_W-1:0] ord_mem [MAX_PARTICLES];

   // load datapath
   req_type item_ff;
   logic [1:0] step_ff;
   logic [32:0] dx_ff, dy_ff;
   logic [56:0] prod_ff;
   logic [56:0] hi_ff;
   logic [31:0] cx_ff;

   // sort datapath
   logic [CNT_W-1:0] i_ff, j_ff, k_ff;
   logic [IDX_W-1:0] key_ff, prev_ff;
   logic [63:0] kc_ff;
   logic [IDX_W-1:0] ord_rd_ff;
   logic [63:0] code_rd_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   logic csr_wr;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_paddr)
         REG_LEFT: csr_prdata = {{32{left_ff[31]}}, left_ff};
         REG_BOTTOM: csr_prdata = {{32{bottom_ff[31]}}, bottom_ff};
         REG_SCALE_X: csr_prdata = {16'd0, scale_x_ff};
         REG_SCALE_Y: csr_prdata = {16'd0, scale_y_ff};
         default: csr_prdata = 64'd0;
      endcase
   end

   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_ff;

   logic accept;
   assign accept = req.valid && req.ready;

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp.ready;

   // shared multiplier: step 0 x-hi, 1 x-lo, 2 y-hi, 3 y-lo
   logic [32:0] mul_a;
   logic [23:0] mul_b;
   logic [47:0] scl;
   always_comb begin
      scl = step_ff[1] ? scale_y_ff : scale_x_ff;
      mul_a = step_ff[1] ? dy_ff : dx_ff;
      mul_b = step_ff[0] ? scl[23:0] : scl[47:24];
   end

   // combine hi and lo products
   logic [57:0] t_sum;
   logic [49:0] r_sum;
   always_comb begin
      t_sum = {1'b0, prod_ff} + {26'd0, hi_ff[7:0], 24'd0};
      r_sum = {1'b0, hi_ff[56:8]} + {24'd0, t_sum[57:32]};
   end

   function automatic logic [32:0] pos_diff(logic signed [31:0] p, logic signed [31:0] b);
      logic signed [32:0] d;
      d = 33'(p) - 33'(b);
      pos_diff = d[32] ? 33'd0 : d;
   endfunction

   function automatic logic [63:0] interleave(logic [31:0] x, logic [31:0] y);
      for (int b = 0; b < 32; b++) begin
         interleave[2*b] = x[b];
         interleave[2*b+1] = y[b];
      end
   endfunction

   logic [31:0] sat_cell;
   assign sat_cell = (r_sum > {18'd0, CELL_MAX}) ? CELL_MAX : r_sum[31:0];

   logic [IDX_W-1:0] jm1;
   assign jm1 = IDX_W'(j_ff - CNT_W'(1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = (count_ff < CNT_W'(MAX_PARTICLES)) ? ST_MUL :
            (req.data.last_in ? ST_SORT_I : ST_IDLE);
         ST_MUL: if (step_ff == 2'd3) state_in = ST_WRITE;
         ST_WRITE: state_in = item_ff.last_in ? ST_SORT_I : ST_IDLE;
         ST_SORT_I: state_in = (i_ff < count_ff) ? ST_SORT_K : ST_OUT_RD;
         ST_SORT_K: state_in = ST_SORT_J;
         ST_SORT_J: state_in = (j_ff == '0) ? ST_SORT_P : ST_SORT_C;
         ST_SORT_C: state_in = ST_SORT_M;
         ST_SORT_M: state_in = (code_rd_ff > kc_ff) ? ST_SORT_J : ST_SORT_P;
         ST_SORT_P: state_in = ST_SORT_I;
         ST_OUT_RD: state_in = (k_ff < count_ff) ? ST_OUT_LD : ST_IDLE;
         ST_OUT_LD: if (out_free) state_in = ST_OUT_RD;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         left_ff <= '0;
         bottom_ff <= '0;
         scale_x_ff <= 48'd65536;
         scale_y_ff <= 48'd65536;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr) begin
            case (csr_paddr)
               REG_LEFT: left_ff <= csr_pwdata[31:0];
               REG_BOTTOM: bottom_ff <= csr_pwdata[31:0];
               REG_SCALE_X: scale_x_ff <= csr_pwdata[47:0];
               REG_SCALE_Y: scale_y_ff <= csr_pwdata[47:0];
               default: ;
            endcase
         end
         if (state_ff == ST_OUT_LD && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_IDLE && accept && count_ff >= CNT_W'(MAX_PARTICLES))
            ovf_ff <= 1'b1;
         if (state_ff == ST_WRITE) count_ff <= count_ff + CNT_W'(1);
         if (state_ff == ST_OUT_RD && k_ff >= count_ff) begin
            count_ff <= '0;
            ovf_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            item_ff <= req.data;
            dx_ff <= pos_diff(req.data.position_x, left_ff);
            dy_ff <= pos_diff(req.data.position_y, bottom_ff);
            step_ff <= 2'd0;
            i_ff <= CNT_W'(1);
            k_ff <= '0;
         end
         ST_MUL: begin
            step_ff <= step_ff + 2'd1;
            prod_ff <= mul_a * mul_b;
            // odd steps keep the hi product, step 2 latches the x cell
            if (step_ff[0]) hi_ff <= prod_ff;
            if (step_ff == 2'd2) cx_ff <= sat_cell;
         end
         ST_WRITE: begin
            pos_mem[count_ff[IDX_W-1:0]] <= {item_ff.position_y, item_ff.position_x};
            vel_mem[count_ff[IDX_W-1:0]] <= {item_ff.velocity_y, item_ff.velocity_x};
            mass_mem[count_ff[IDX_W-1:0]] <= item_ff.mass_word;
            code_mem[count_ff[IDX_W-1:0]] <= interleave(cx_ff, sat_cell);
            ord_mem[count_ff[IDX_W-1:0]] <= count_ff[IDX_W-1:0];
         end
         ST_SORT_I: begin
            key_ff <= ord_mem[i_ff[IDX_W-1:0]];
            j_ff <= i_ff;
         end
         ST_SORT_K: kc_ff <= code_mem[key_ff];
         ST_SORT_J: prev_ff <= ord_mem[jm1];
         ST_SORT_C: code_rd_ff <= code_mem[prev_ff];
         ST_SORT_M: if (code_rd_ff > kc_ff) begin
            ord_mem[j_ff[IDX_W-1:0]] <= prev_ff;
            j_ff <= j_ff - CNT_W'(1);
         end
         ST_SORT_P: begin
            ord_mem[j_ff[IDX_W-1:0]] <= key_ff;
            i_ff <= i_ff + CNT_W'(1);
         end
         ST_OUT_RD: ord_rd_ff <= ord_mem[k_ff[IDX_W-1:0]];
         // load only once the output register is free
         ST_OUT_LD: if (out_free) begin
            rsp_ff.sorted_x <= pos_mem[ord_rd_ff][31:0];
            rsp_ff.sorted_y <= pos_mem[ord_rd_ff][63:32];
            rsp_ff.sorted_mass <= mass_mem[ord_rd_ff];
            rsp_ff.sorted_vel_x <= vel_mem[ord_rd_ff][31:0];
            rsp_ff.sorted_vel_y <= vel_mem[ord_rd_ff][63:32];
            rsp_ff.morton_code <= code_mem[ord_rd_ff];
            rsp_ff.source_index <= 6'(ord_rd_ff);
            rsp_ff.overflowed <= ovf_ff;
            rsp_ff.last_out <= (k_ff + CNT_W'(1) == count_ff);
            k_ff <= k_ff + CNT_W'(1);
         end
         default: ;
      endcase
   end
endmodule

@@ bench/morton_zorder_particle_sort_tb.sv @@
// ----------------------------------------------------------------------------
// morton_zorder_particle_sort_tb: self-checking bench for the z-order sorter
// drives particle sets with bursty valid and a stalling receiver. the csr
// port is rewritten between phases. every sorted result is checked against
// an in-bench model of quantization, interleaving and stable sorting.
// ----------------------------------------------------------------------------
module morton_zorder_particle_sort_tb import mzs_pkg::*; ;

   localparam int WATCHDOG_LIMIT = 40000;

   typedef struct {
      req_type item;
      bit has_code;
      logic [63:0] code;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic csr_pready;

   mzs_req_if req ();
   mzs_rsp_if rsp ();

   morton_zorder_particle_sort dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #6 clock = ~clock;

   // model copy of configuration and set contents
   logic signed [31:0] mdl_left, mdl_bottom;
   logic [47:0] mdl_scale_x, mdl_scale_y;
   req_type set_items[MAX_PARTICLES];
   logic [63:0] set_codes[MAX_PARTICLES];
   int set_count;
   bit set_overflow;
   rsp_type sorted_q[$];
   bit code_override;
   logic [63:0] code_typed;

   int errors = 0;
   int idle_cycles = 0;
   int stall_pct = 0;
   int stall_timer = 0;
   bit csr_write_fire;

   function automatic logic [31:0] grid_cell(logic signed [31:0] pos,
         logic signed [31:0] bound, logic [47:0] scale);
      longint d;
      logic [80:0] prod;
      logic [80:0] r;
      d = longint'(pos) - longint'(bound);
      if (d <= 0) return 32'd0;
      prod = 81'(d) * 81'(scale);
      r = prod >> 32;
      return (r > 81'(CELL_MAX)) ? CELL_MAX : r[31:0];
   endfunction

   function automatic logic [63:0] z_interleave(logic [31:0] cx, logic [31:0] cy);
      logic [63:0] z;
      z = '0;
      for (int b = 0; b < 32; b++) begin
         z[2*b] = cx[b];
         z[2*b+1] = cy[b];
      end
      return z;
   endfunction

   // update the model with one accepted particle; on last_in queue the sorted run
   task automatic load_particle(req_type it);
      int ord[MAX_PARTICLES];
      int key, j;
      rsp_type r;
      if (set_count < MAX_PARTICLES) begin
         set_items[set_count] = it;
         set_codes[set_count] = z_interleave(grid_cell(it.position_x, mdl_left, mdl_scale_x),
                                             grid_cell(it.position_y, mdl_bottom, mdl_scale_y));
         set_count++;
      end else begin
         set_overflow = 1'b1;
      end
      if (!it.last_in) return;
      for (int i = 0; i < set_count; i++) ord[i] = i;
      for (int i = 1; i < set_count; i++) begin
         key = ord[i];
         j = i;
         while (j > 0 && set_codes[ord[j-1]] > set_codes[key]) begin
            ord[j] = ord[j-1];
            j--;
         end
         ord[j] = key;
      end
      for (int k = 0; k < set_count; k++) begin
         r.sorted_x = set_items[ord[k]].position_x;
         r.sorted_y = set_items[ord[k]].position_y;
         r.sorted_mass = set_items[ord[k]].mass_word;
         r.sorted_vel_x = set_items[ord[k]].velocity_x;
         r.sorted_vel_y = set_items[ord[k]].velocity_y;
         r.morton_code = (code_override && set_count == 1) ? code_typed : set_codes[ord[k]];
         r.source_index = 6'(ord[k]);
         r.overflowed = set_overflow;
         r.last_out = (k == set_count - 1);
         sorted_q.push_back(r);
      end
      set_count = 0;
      set_overflow = 1'b0;
   endtask

   task automatic send_particle(req_type it);
      @(negedge clock);
      req.valid <= 1'b1;
      req.data <= it;
      do @(posedge clock); while (!req.ready);
      load_particle(it);
   endtask

   // random gap before a particle, sender works in bursts
   task automatic maybe_gap();
      int n;
      if ($urandom_range(0, 3) != 0) return;
      n = $urandom_range(1, 12);
      repeat (n) begin
         @(negedge clock);
         req.valid <= 1'b0;
      end
   endtask

   task automatic csr_write(logic [ADDR_W-1:0] addr, logic [63:0] value);
      @(negedge clock);
      req.valid <= 1'b0;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (addr)
         REG_LEFT: mdl_left = value[31:0];
         REG_BOTTOM: mdl_bottom = value[31:0];
         REG_SCALE_X: mdl_scale_x = value[47:0];
         REG_SCALE_Y: mdl_scale_y = value[47:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req.valid <= 1'b0;
      while (sorted_q.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_config(logic [63:0] l, logic [63:0] b, logic [63:0] sx,
         logic [63:0] sy);
      csr_write(REG_LEFT, l);
      csr_write(REG_BOTTOM, b);
      csr_write(REG_SCALE_X, sx);
      csr_write(REG_SCALE_Y, sy);
   endtask

   function automatic req_type rand_particle(bit last);
      req_type it;
      it.mass_word = $urandom;
      it.velocity_x = $urandom;
      it.velocity_y = $urandom;
      if ($urandom_range(0, 1)) begin
         it.position_x = $urandom;
         it.position_y = $urandom;
      end else begin
         // land near the domain corner so cells stay in range
         it.position_x = mdl_left + 32'($urandom_range(0, 32'h00ff_ffff)) - 32'h100;
         it.position_y = mdl_bottom + 32'($urandom_range(0, 32'h00ff_ffff)) - 32'h100;
      end
      if ($urandom_range(0, 7) == 0) it.position_x = mdl_left;
      it.last_in = last;
      return it;
   endfunction

   task automatic send_set(int n);
      req_type it, dup;
      for (int i = 0; i < n; i++) begin
         it = rand_particle(i == n - 1);
         // occasional repeated position to exercise tie order
         if (i > 0 && $urandom_range(0, 4) == 0) begin
            it.position_x = dup.position_x;
            it.position_y = dup.position_y;
         end
         dup = it;
         maybe_gap();
         send_particle(it);
      end
   endtask

   task automatic cmp_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %h, actual %h", name, exp_v, act_v);
         errors++;
      end
   endtask

   // receiver: stall pattern is redrawn whenever stall_timer runs out
   always @(negedge clock) begin
      if (stall_timer == 0) begin
         stall_timer = 64;
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 30;
            2: stall_pct = 70;
            default: stall_pct = 95;
         endcase
      end
      stall_timer--;
      rsp.ready <= ($urandom_range(1, 100) > stall_pct);
   end

   always @(posedge clock) begin
      rsp_type e;
      csr_write_fire = csr_psel && csr_penable && csr_pwrite && csr_pready;
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || csr_write_fire)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
      if (!reset && rsp.valid && rsp.ready) begin
         if (sorted_q.size() == 0) begin
            $error("result transfer with nothing pending");
            errors++;
         end else begin
            e = sorted_q.pop_front();
            cmp_field("sorted_x", 64'(e.sorted_x), 64'(rsp.data.sorted_x));
            cmp_field("sorted_y", 64'(e.sorted_y), 64'(rsp.data.sorted_y));
            cmp_field("sorted_mass", 64'(e.sorted_mass), 64'(rsp.data.sorted_mass));
            cmp_field("sorted_vel_x", 64'(e.sorted_vel_x), 64'(rsp.data.sorted_vel_x));
            cmp_field("sorted_vel_y", 64'(e.sorted_vel_y), 64'(rsp.data.sorted_vel_y));
            cmp_field("morton_code", e.morton_code, rsp.data.morton_code);
            cmp_field("source_index", 64'(e.source_index), 64'(rsp.data.source_index));
            cmp_field("overflowed", 64'(e.overflowed), 64'(rsp.data.overflowed));
            cmp_field("last_out", 64'(e.last_out), 64'(rsp.data.last_out));
         end
      end
   end

   stim_row_type dir_rows[9];

   initial begin
      req.valid = 1'b0;
      req.data = '0;
      mdl_left = 0;
      mdl_bottom = 0;
      mdl_scale_x = 48'd65536;
      mdl_scale_y = 48'd65536;
      set_count = 0;
      set_overflow = 1'b0;
      code_override = 1'b0;

      // reset defaults: cell is the integer part of the position
      dir_rows[0] = '{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1}, 1, 64'h0};
      dir_rows[1] = '{'{32'h0001_0000, 32'h0, 32'h1, 32'h2, 32'h3, 1'b1}, 1, 64'h1};
      dir_rows[2] = '{'{32'h0, 32'h0001_0000, 32'h4, 32'h5, 32'h6, 1'b1}, 1, 64'h2};
      dir_rows[3] = '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 1'b1}, 1, 64'h0};
      dir_rows[4] = '{'{32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                        32'hffff_ffff, 1'b1}, 1, 64'h3fff_ffff};
      dir_rows[5] = '{'{32'h0003_0000, 32'h0003_0000, 32'ha, 32'ha, 32'ha, 1'b0}, 0, 64'h0};
      dir_rows[6] = '{'{32'h0001_0000, 32'h0, 32'hb, 32'hb, 32'hb, 1'b0}, 0, 64'h0};
      dir_rows[7] = '{'{32'h0003_0000, 32'h0003_0000, 32'hc, 32'hc, 32'hc, 1'b1}, 0, 64'h0};
      dir_rows[8] = '{'{32'h0002_0000, 32'h0002_0000, 32'hd, 32'he, 32'hf, 1'b1}, 1, 64'hc};

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         code_override = dir_rows[i].has_code;
         code_typed = dir_rows[i].code;
         maybe_gap();
         send_particle(dir_rows[i].item);
      end
      code_override = 1'b0;
      wait_drain();

      // saturation at both ends of the cell range
      write_config(64'h8000_0000, 64'h7fff_ffff, 64'hffff_ffff_ffff, 64'h0);
      send_set(5);
      wait_drain();

      // a full set, then one with dropped particles, last_in on a dropped one
      write_config({$urandom, $urandom}, {$urandom, $urandom}, 64'd65536, 64'd65536);
      send_set(MAX_PARTICLES);
      wait_drain();
      send_set(MAX_PARTICLES + 2);
      wait_drain();

      for (int ph = 0; ph < 6; ph++) begin
         write_config({$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom} >> $urandom_range(16, 40),
                      {$urandom, $urandom} >> $urandom_range(16, 40));
         for (int s = 0; s < 4; s++) begin
            send_set($urandom_range(1, 6));
         end
         wait_drain();
      end

      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule

@@ filelist.f @@
sv/mzs_pkg.sv
sv/mzs_if.sv
sv/morton_zorder_particle_sort.sv
bench/morton_zorder_particle_sort_tb.sv
